/* hdl/dcd_pkg.sv */
// Shared types, DES tables and DES helper functions for the framed CBC decoder.
package dcd_pkg;

  // Frame parser phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_GOT1 = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // One gathered ciphertext block with its emit count and frame marker
  typedef struct packed {
    logic [63:0] block;
    logic [3:0]  cnt;
    logic        flast;
  } blk_t;

  typedef logic [15:0][47:0] rkeys_t;

  localparam int unsigned QDepth = 2;

  localparam logic [6:0] IP_T [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7 };
  localparam logic [6:0] FP_T [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25 };
  localparam logic [5:0] E_T [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1 };
  localparam logic [5:0] P_T [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25 };
  localparam logic [6:0] PC1_T [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4 };
  localparam logic [5:0] PC2_T [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32 };
  localparam logic [1:0] ROT_T [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11} };

  // Table entries count bit positions from the MSB, starting at one
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(IP_T[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-int'(FP_T[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[32-int'(E_T[i])];
    return r;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) r[31-i] = v[32-int'(P_T[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-int'(PC1_T[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-int'(PC2_T[i])];
    return r;
  endfunction

  // Key schedule: pure wiring, the rotations are fixed per round
  function automatic rkeys_t make_rkeys(input logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    rkeys_t      rk;
    cd = perm_pc1(key);
    c  = cd[55:28];
    d  = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      if (ROT_T[i] == 2'd1) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end else begin
        c = {c[25:0], c[27:26]};
        d = {d[25:0], d[27:26]};
      end
      rk[i] = perm_pc2({c, d});
    end
    return rk;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] o;
    x = perm_e(r) ^ k;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      o[31-4*i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
    end
    return perm_p(o);
  endfunction

endpackage

/* hdl/dcd_front.sv */
// Frame parser: reads the length header and gathers payload bytes into blocks.
module dcd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  output logic          push_o,
  output dcd_pkg::blk_t push_blk_o,
  input  logic          full_i
);
  import dcd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] dleft_q, dleft_d;
  logic [16:0] cleft_q, cleft_d;
  logic [2:0]  fill_q, fill_d;
  logic [55:0] buf_q, buf_d;
  logic [15:0] len;
  logic [3:0]  n;
  logic        fire;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign len        = {dleft_q[7:0], in_byte_i};
  assign n          = (dleft_q < 16'd8) ? dleft_q[3:0] : 4'd8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dleft_q <= '0;
      cleft_q <= '0;
      fill_q  <= '0;
    end else begin
      phase_q <= phase_d;
      dleft_q <= dleft_d;
      cleft_q <= cleft_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Next state and block hand-off
  always_comb begin
    phase_d    = phase_q;
    dleft_d    = dleft_q;
    cleft_d    = cleft_q;
    fill_d     = fill_q;
    buf_d      = buf_q;
    push_o     = 1'b0;
    push_blk_o.block = {buf_q, in_byte_i};
    push_blk_o.cnt   = n;
    push_blk_o.flast = (dleft_q <= 16'd8);
    if (fire) begin
      case (phase_q)
        PH_GOT1: begin
          dleft_d = len;
          cleft_d = ({1'b0, len} + 17'd7) & ~17'd7;
          fill_d  = '0;
          phase_d = (len == 16'd0) ? PH_IDLE : PH_DATA;
        end
        PH_DATA: begin
          buf_d  = {buf_q[47:0], in_byte_i};
          fill_d = fill_q + 3'd1;
          if (fill_q == 3'd7) begin
            push_o  = 1'b1;
            dleft_d = dleft_q - {12'd0, n};
            if (cleft_q <= 17'd8) begin
              phase_d = PH_IDLE;
              dleft_d = '0;
              cleft_d = '0;
              fill_d  = '0;
            end else begin
              cleft_d = cleft_q - 17'd8;
            end
          end
        end
        default: begin
          dleft_d = {8'd0, in_byte_i};
          cleft_d = '0;
          fill_d  = '0;
          phase_d = PH_GOT1;
        end
      endcase
    end
  end

endmodule

/* hdl/dcd_queue.sv */
// Short block queue between the parser and the decrypt engine.
module dcd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dcd_pkg::blk_t push_blk_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dcd_pkg::blk_t pop_blk_o
);
  import dcd_pkg::*;

  blk_t       mem [QDepth];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o    = (cnt_q == 2'(QDepth));
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_blk_o = mem[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_blk_i;
    end
  end

endmodule

/* hdl/dcd_back.sv */
// Decrypt engine (two DES rounds a cycle, CBC chaining) and byte serialiser.
module dcd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   key_i,
  input  logic          q_valid_i,
  input  dcd_pkg::blk_t q_blk_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_frame_end_o,
  output logic          out_run_end_o
);
  import dcd_pkg::*;

  rkeys_t      rk;
  logic        busy_q, busy_d;
  logic [2:0]  rnd_q, rnd_d;
  logic [31:0] l_q, l_d, r_q, r_d;
  blk_t        cur_q, cur_d;
  logic [63:0] chain_q, chain_d;
  logic        ob_v_q, ob_v_d;
  logic [63:0] ob_pl_q, ob_pl_d;
  logic [3:0]  ob_cnt_q, ob_cnt_d;
  logic        ob_fl_q, ob_fl_d;
  logic [2:0]  ob_idx_q, ob_idx_d;
  logic [3:0]  ka, kb;
  logic [31:0] r1, r2;
  logic [63:0] ipv, plain;
  logic        ob_last, ob_fire, load_ok, finish;

  assign rk = make_rkeys(key_i);

  // Two rounds per cycle, decryption takes the round keys in reverse
  assign ka    = 4'd15 - {rnd_q, 1'b0};
  assign kb    = 4'd14 - {rnd_q, 1'b0};
  assign r1    = l_q ^ feistel(r_q, rk[ka]);
  assign r2    = r_q ^ feistel(r1, rk[kb]);
  assign plain = perm_fp({r2, r1}) ^ chain_q;
  assign ipv   = perm_ip(q_blk_i.block);

  // Output buffer status
  assign ob_last  = ({1'b0, ob_idx_q} == ob_cnt_q - 4'd1);
  assign ob_fire  = ob_v_q && out_ready_i;
  assign load_ok  = !ob_v_q || (ob_fire && ob_last);
  assign finish   = busy_q && (rnd_q == 3'd7) && load_ok;
  assign pop_o    = q_valid_i && (!busy_q || finish);

  assign out_valid_o     = ob_v_q;
  assign out_byte_o      = ob_pl_q[63 - 8*ob_idx_q -: 8];
  assign out_run_end_o   = ob_last;
  assign out_frame_end_o = ob_last && ob_fl_q;

  always_comb begin
    busy_d   = busy_q;
    rnd_d    = rnd_q;
    l_d      = l_q;
    r_d      = r_q;
    cur_d    = cur_q;
    chain_d  = chain_q;
    ob_v_d   = ob_v_q;
    ob_pl_d  = ob_pl_q;
    ob_cnt_d = ob_cnt_q;
    ob_fl_d  = ob_fl_q;
    ob_idx_d = ob_idx_q;
    // serialiser advance
    if (ob_fire) begin
      if (ob_last) begin
        ob_v_d = 1'b0;
      end else begin
        ob_idx_d = ob_idx_q + 3'd1;
      end
    end
    // round iteration
    if (busy_q && rnd_q != 3'd7) begin
      l_d   = r1;
      r_d   = r2;
      rnd_d = rnd_q + 3'd1;
    end
    // block done: chain update and hand-off; padding-only blocks vanish
    if (finish) begin
      busy_d  = 1'b0;
      chain_d = cur_q.block;
      if (cur_q.cnt != 4'd0) begin
        ob_v_d   = 1'b1;
        ob_pl_d  = plain;
        ob_cnt_d = cur_q.cnt;
        ob_fl_d  = cur_q.flast;
        ob_idx_d = '0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      rnd_d  = '0;
      l_d    = ipv[63:32];
      r_d    = ipv[31:0];
      cur_d  = q_blk_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rnd_q   <= '0;
      ob_v_q  <= 1'b0;
      chain_q <= '0;
    end else begin
      busy_q  <= busy_d;
      rnd_q   <= rnd_d;
      ob_v_q  <= ob_v_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q      <= l_d;
    r_q      <= r_d;
    cur_q    <= cur_d;
    ob_pl_q  <= ob_pl_d;
    ob_cnt_q <= ob_cnt_d;
    ob_fl_q  <= ob_fl_d;
    ob_idx_q <= ob_idx_d;
  end

endmodule

/* hdl/des_cbc_length_framed_decoder.sv */
// Top level of the length-framed DES-CBC stream decoder.
// Takes one ciphertext byte per cycle while the block queue is not full.
// Each frame is a two-byte big-endian plaintext length followed by that
// length rounded up to 8-byte blocks; each block is DES-decrypted with the
// configured key and chained (CBC, zero IV at reset, chaining kept across
// frames). Only plaintext bytes within the frame length come out, one per
// cycle while the receiver is ready; tlast marks the last byte of a frame
// and tuser the last byte of a block. The decrypt engine (two Feistel
// rounds a cycle) works on the next block while one is serialised, so with
// full blocks the sustained rate is one byte per cycle. Write the key only
// while the block is idle.
module des_cbc_length_framed_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,    // des_key
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] cipher_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] plain_byte
  output logic        m_axis_tlast,  // frame_end
  output logic [0:0]  m_axis_tuser   // [0] run_end
);
  import dcd_pkg::*;

  logic [63:0] key_q;
  logic        push, full, q_valid, pop, run_end;
  blk_t        push_blk, q_blk;

  // Key register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      key_q <= cfg_data_i;
    end
  end

  dcd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .push_blk_o (push_blk),
    .full_i     (full)
  );

  dcd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_blk_i (push_blk),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_blk_o  (q_blk)
  );

  dcd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .key_i           (key_q),
    .q_valid_i       (q_valid),
    .q_blk_i         (q_blk),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_byte_o      (m_axis_tdata),
    .out_frame_end_o (m_axis_tlast),
    .out_run_end_o   (run_end)
  );

  assign m_axis_tuser = run_end;

endmodule
